/* sv/sv39pt_pkg.sv */
// Shared package for the Sv39 page table walker.
// Holds the size defaults, status codes and the result record; no dependencies.
package sv39pt_pkg;

    // Default number of 512-entry table pages held in the store.
    localparam int TABLE_PAGES_DEF   = 16;
    localparam int ENTRIES_PER_TABLE = 512;
    localparam int LEVEL_BITS        = 9;

    localparam int STATUS_W = 3;
    localparam int PPN_W    = 44;
    localparam int ENTRY_W  = 64;
    localparam int INDEX_W  = 13;
    localparam int VA_W     = 64;
    localparam int VPN_W    = 3 * LEVEL_BITS;
    localparam int ROOT_W   = 4;

    // Entry word layout.
    localparam int FLAG_V_BIT = 0;
    localparam int FLAG_U_BIT = 4;
    localparam int PPN_LSB    = 10;

    // Virtual addresses at or above 2^38 are rejected.
    localparam int VA_LIMIT_BIT = 38;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_TOO_LARGE = 3'd1;
    localparam logic [STATUS_W-1:0] ST_INVALID   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_USER  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_OUTSIDE   = 3'd4;

    // Item kinds on the input tuser bit.
    localparam logic OP_WRITE     = 1'b0;
    localparam logic OP_TRANSLATE = 1'b1;

    // Configuration register byte addresses.
    localparam logic [2:0] ADDR_ROOT_TABLE_PAGE = 3'd0;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [PPN_W-1:0]    ppn;
    } res_t;

endpackage

/* sv/sv39_page_table_translate.sv */
// Top level of the Sv39 page table walker: APB register, stream channels,
// table store and output register. Depends on sv39pt_pkg, sv39pt_ram, sv39pt_walker.
//
// Usage. Items arrive on the s_ channel; s_tuser selects the kind of item.
// A write item (s_tuser = 0) stores entry_value at store word entry_index;
// an index beyond the store is ignored. A translate item (s_tuser = 1)
// walks the three table levels from the root page and returns the leaf's
// physical page number or a fault status. Every item yields exactly one
// result on the m_ channel, in order.
// Timing: a write item goes straight to its result; a translate item issues
// the read of the root table, then checks each entry read and issues the read
// of the next level from the single store port, then hands the result on,
// and stops early when it faults. The result passes the walker's result
// register and then the output register before it shows on m_tvalid.
// The walker takes one item at a time.
// Reset: aresetn is synchronous and active low. The root page register
// returns to 0 and the store is swept to zero, one word a cycle; s_tready
// stays low during the sweep, while register writes are taken as ever.
// Stall: a result waits in the output register while m_tready is low. The
// walker may still take and work on the next item, and holds its result
// until the output register frees.
module sv39_page_table_translate
    import sv39pt_pkg::*;
#(
    parameter int TABLE_PAGES = TABLE_PAGES_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    // Configuration port.
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    // Input items.
    input  logic         s_tvalid,
    output logic         s_tready,
    // [12:0] entry_index, [76:13] entry_value, [140:77] virtual_address, zero fill
    input  logic [143:0] s_tdata,
    // [0] opcode
    input  logic [0:0]   s_tuser,
    // Result items.
    output logic         m_tvalid,
    input  logic         m_tready,
    // [2:0] status, [46:3] phys_page_number, zero fill
    output logic [47:0]  m_tdata
);

    localparam int DEPTH  = TABLE_PAGES * ENTRIES_PER_TABLE;
    localparam int PAGE_W = (TABLE_PAGES > 1) ? $clog2(TABLE_PAGES) : 1;
    localparam int ADDR_W = PAGE_W + LEVEL_BITS;

    logic [ROOT_W-1:0] root_reg, root_next;
    logic              m_valid_reg, m_valid_next;
    res_t              out_reg, out_next;

    logic               res_valid, res_ready;
    res_t               res;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_addr;
    logic [ENTRY_W-1:0] mem_wdata, mem_rdata;
    logic               cfg_wr;

    // Register file: the root page register sits at byte address 0.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        root_next = root_reg;
        if (cfg_wr && paddr[2] == ADDR_ROOT_TABLE_PAGE[2]) begin
            root_next = pwdata[ROOT_W-1:0];
        end
    end

    assign prdata = (paddr[2] == ADDR_ROOT_TABLE_PAGE[2]) ? {28'd0, root_reg} : 32'd0;

    sv39pt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    sv39pt_walker #(
        .TABLE_PAGES (TABLE_PAGES),
        .PAGE_W      (PAGE_W),
        .ADDR_W      (ADDR_W)
    ) u_walker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .root_page (root_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_opcode (s_tuser[0]),
        .in_index  (s_tdata[12:0]),
        .in_value  (s_tdata[76:13]),
        .in_va     (s_tdata[140:77]),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .mem_we    (mem_we),
        .mem_addr  (mem_addr),
        .mem_wdata (mem_wdata),
        .mem_rdata (mem_rdata)
    );

    // Output register: it loads whenever it is empty or being emptied.
    assign res_ready = !m_valid_reg || m_tready;

    always_comb begin
        m_valid_next = m_valid_reg;
        out_next     = out_reg;
        if (res_ready) begin
            m_valid_next = res_valid;
            if (res_valid) begin
                out_next = res;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            root_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            root_reg    <= root_next;
            m_valid_reg <= m_valid_next;
        end
        out_reg <= out_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, out_reg.ppn, out_reg.status};

endmodule

/* sv/sv39pt_ram.sv */
// Generic single-port synchronous RAM with a registered read.
// No dependencies.
module sv39pt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8192
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

/* sv/sv39pt_walker.sv */
// Walk sequencer: clearing pass, entry writes and the three-level table walk.
// Depends on sv39pt_pkg; drives the port of one sv39pt_ram instance.
module sv39pt_walker
    import sv39pt_pkg::*;
#(
    parameter int TABLE_PAGES = TABLE_PAGES_DEF,
    parameter int PAGE_W      = (TABLE_PAGES > 1) ? $clog2(TABLE_PAGES) : 1,
    parameter int ADDR_W      = PAGE_W + LEVEL_BITS
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [ROOT_W-1:0]  root_page,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               in_opcode,
    input  logic [INDEX_W-1:0] in_index,
    input  logic [ENTRY_W-1:0] in_value,
    input  logic [VA_W-1:0]    in_va,
    output logic               res_valid,
    input  logic               res_ready,
    output res_t               res,
    output logic               mem_we,
    output logic [ADDR_W-1:0]  mem_addr,
    output logic [ENTRY_W-1:0] mem_wdata,
    input  logic [ENTRY_W-1:0] mem_rdata
);

    localparam int DEPTH = TABLE_PAGES * ENTRIES_PER_TABLE;
    // One bit above the wider of the two index widths, so that DEPTH itself fits.
    localparam int XW    = ((ADDR_W > INDEX_W) ? ADDR_W : INDEX_W) + 1;
    localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(DEPTH - 1);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_READ  = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [ADDR_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic [1:0]        level_reg, level_next;
    logic [VPN_W-1:0]  vpn_reg, vpn_next;
    res_t              res_reg, res_next;

    logic                  mem_re;
    logic [XW-1:0]         idx_x;
    logic [PPN_W-1:0]      e_ppn;
    logic [LEVEL_BITS-1:0] next_idx;

    assign idx_x = XW'(in_index);
    assign e_ppn = mem_rdata[PPN_LSB +: PPN_W];
    // Level just read is level_reg; the next table is indexed by the level below.
    assign next_idx = (level_reg == 2'd2) ? vpn_reg[LEVEL_BITS +: LEVEL_BITS]
                                          : vpn_reg[0 +: LEVEL_BITS];

    always_comb begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        level_next   = level_reg;
        vpn_next     = vpn_reg;
        res_next     = res_reg;
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        mem_addr     = clr_cnt_reg;
        mem_wdata    = '0;
        case (state_reg)
            S_CLEAR: begin
                mem_we       = 1'b1;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == CLR_LAST) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_valid) begin
                    state_next = S_DONE;
                    res_next   = '{status: ST_OK, ppn: '0};
                    vpn_next   = in_va[12 +: VPN_W];
                    if (in_opcode == OP_WRITE) begin
                        // Writes beyond the store are dropped silently.
                        if (idx_x < XW'(DEPTH)) begin
                            mem_we    = 1'b1;
                            mem_addr  = idx_x[ADDR_W-1:0];
                            mem_wdata = in_value;
                        end
                    end else if (in_va[VA_W-1:VA_LIMIT_BIT] != '0) begin
                        res_next.status = ST_TOO_LARGE;
                    end else if ({5'd0, root_page} >= 9'(TABLE_PAGES)) begin
                        res_next.status = ST_OUTSIDE;
                    end else begin
                        mem_re     = 1'b1;
                        mem_addr   = {PAGE_W'(root_page),
                                      in_va[12 + 2*LEVEL_BITS +: LEVEL_BITS]};
                        level_next = 2'd2;
                        state_next = S_READ;
                    end
                end
            end
            S_READ: begin
                if (!mem_rdata[FLAG_V_BIT]) begin
                    res_next.status = ST_INVALID;
                    state_next      = S_DONE;
                end else if (level_reg == 2'd0) begin
                    if (!mem_rdata[FLAG_U_BIT]) begin
                        res_next.status = ST_NOT_USER;
                    end else begin
                        res_next.ppn = e_ppn;
                    end
                    state_next = S_DONE;
                end else if (e_ppn >= PPN_W'(TABLE_PAGES)) begin
                    res_next.status = ST_OUTSIDE;
                    state_next      = S_DONE;
                end else begin
                    mem_re     = 1'b1;
                    mem_addr   = {e_ppn[PAGE_W-1:0], next_idx};
                    level_next = level_reg - 1'b1;
                end
            end
            S_DONE: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_cnt_reg <= '0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
        end
        level_reg <= level_next;
        vpn_reg   <= vpn_next;
        res_reg   <= res_next;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res       = res_reg;

    a_read_then_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_re |=> state_reg == S_READ)
        else $error("table read issued without waiting for its data");

    a_no_rw_clash: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> !mem_re)
        else $error("store written while a walk read is issued");

    a_ppn_only_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> (res.status == ST_OK || res.ppn == '0))
        else $error("page number set on a faulting result");

    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> (res.status == ST_OK || res.status == ST_TOO_LARGE ||
                       res.status == ST_INVALID || res.status == ST_NOT_USER ||
                       res.status == ST_OUTSIDE))
        else $error("undefined status code");

endmodule
